// File: rtl/xad_pkg.sv
// Package with widths, coefficient tables and shared types for the XA ADPCM decoder.
`timescale 1ns / 1ps

package xad_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 25;
    localparam int SUM_W    = 20;

    localparam logic [3:0] SHIFT_LIMIT   = 4'd12;
    localparam logic [3:0] SHIFT_CLAMPED = 4'd9;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS = 25'sd32;
    localparam logic signed [SUM_W-1:0]  SAT_HIGH   = 20'sd32767;
    localparam logic signed [SUM_W-1:0]  SAT_LOW    = -20'sd32768;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // One channel's history as it enters the decode logic.
    typedef struct packed {
        sample_t prev1;
        sample_t prev2;
    } history_t;

    // Block parameters of one channel, as laid out in the parameter byte.
    typedef struct packed {
        logic [1:0] unused;
        logic [1:0] filt;
        logic [3:0] shift;
    } params_t;

    function automatic logic signed [7:0] coef_k0(input logic [1:0] filt);
        logic signed [7:0] k;
        unique case (filt)
            2'd0: k = 8'sd0;
            2'd1: k = 8'sd60;
            2'd2: k = 8'sd115;
            2'd3: k = 8'sd98;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

    function automatic logic signed [7:0] coef_k1(input logic [1:0] filt);
        logic signed [7:0] k;
        unique case (filt)
            2'd0: k = 8'sd0;
            2'd1: k = 8'sd0;
            2'd2: k = -8'sd52;
            2'd3: k = -8'sd55;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/xad_channel.sv
// Combinational decode of one ADPCM nibble against its channel history.
`timescale 1ns / 1ps

module xad_channel
    import xad_pkg::*;
(
    input  logic [3:0] code,
    input  params_t    params,
    input  history_t   hist,
    output sample_t    sample
);

    logic [3:0]                eff_shift;
    logic [3:0]                scale_amt;
    logic signed [SUM_W-1:0]   nib_ext;
    logic signed [SUM_W-1:0]   scaled;
    logic signed [PROD_W-1:0]  acc;
    logic signed [PROD_W-1:0]  pred_full;
    logic signed [SUM_W-1:0]   pred;
    logic signed [SUM_W-1:0]   total;

    always_comb
    begin
        // Shift fields above twelve fall back to nine.
        eff_shift = (params.shift > SHIFT_LIMIT) ? SHIFT_CLAMPED : params.shift;
        scale_amt = SHIFT_LIMIT - eff_shift;
        nib_ext   = SUM_W'(signed'(code));
        scaled    = nib_ext <<< scale_amt;

        // Both factors are widened first so the products cannot wrap.
        acc = PROD_W'(coef_k0(params.filt)) * PROD_W'(hist.prev1)
            + PROD_W'(coef_k1(params.filt)) * PROD_W'(hist.prev2)
            + ROUND_BIAS;
        pred_full = acc >>> 6;
        pred      = pred_full[SUM_W-1:0];
        total     = scaled + pred;

        if (total > SAT_HIGH)
        begin
            sample = SAT_HIGH[SAMPLE_W-1:0];
        end
        else if (total < SAT_LOW)
        begin
            sample = SAT_LOW[SAMPLE_W-1:0];
        end
        else
        begin
            sample = total[SAMPLE_W-1:0];
        end
    end

endmodule

// File: rtl/xa_adpcm_stereo_decoder.sv
// Top level of the XA 4-bit stereo ADPCM decoder with its stream interface.
`timescale 1ns / 1ps

// Usage
// The slave channel takes one item per stereo pair: s_tdata carries the packed
// sample byte (low nibble left, high nibble right) and the left and right block
// parameter bytes, and s_tuser carries the restart flag, which clears both
// channel histories before the byte is decoded. The master channel returns
// one item per input item with the saturated left and right PCM samples.
// An accepted item is held in an input register, decoded by short logic for
// both channels in parallel, and moved into the result register that drives
// m_tvalid whenever that register is empty or is being drained. The sustained
// rate is one item per cycle while the receiver does not stall; it is set by
// the history recurrence, which is updated at the same edge as the result register.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item, after which s_tready drops until the
// result is taken. Reset clears both histories and all valid flags.

module xa_adpcm_stereo_decoder
    import xad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // sample_byte[7:0], left_params[15:8], right_params[23:16]
    input  logic        s_tuser,   // restart[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // left_sample[15:0], right_sample[31:16]
);

    logic        in_valid_reg;
    logic [23:0] in_data_reg;
    logic        in_restart_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    sample_t left_prev1_reg, left_prev2_reg;
    sample_t right_prev1_reg, right_prev2_reg;

    logic     advance;
    history_t left_hist, right_hist;
    sample_t  left_next, right_next;

    // The input register moves into the result register whenever the result
    // register is empty or is being drained in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A restart item decodes against a cleared history.
    always_comb
    begin
        if (in_restart_reg)
        begin
            left_hist  = '0;
            right_hist = '0;
        end
        else
        begin
            left_hist  = '{prev1: left_prev1_reg,  prev2: left_prev2_reg};
            right_hist = '{prev1: right_prev1_reg, prev2: right_prev2_reg};
        end
    end

    xad_channel u_left
    (
        .code   (in_data_reg[3:0]),
        .params (params_t'(in_data_reg[15:8])),
        .hist   (left_hist),
        .sample (left_next)
    );

    xad_channel u_right
    (
        .code   (in_data_reg[7:4]),
        .params (params_t'(in_data_reg[23:16])),
        .hist   (right_hist),
        .sample (right_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            left_prev1_reg  <= '0;
            left_prev2_reg  <= '0;
            right_prev1_reg <= '0;
            right_prev2_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                left_prev1_reg  <= left_next;
                left_prev2_reg  <= left_hist.prev1;
                right_prev1_reg <= right_next;
                right_prev2_reg <= right_hist.prev1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
        if (advance)
        begin
            out_data_reg <= {right_next, left_next};
        end
    end

`ifndef SYNTHESIS
    // The history picks up exactly the samples that were delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (left_prev1_reg == m_tdata[15:0]) && (right_prev1_reg == m_tdata[31:16]))
        else $error("history does not match the decoded result");

    // A restart item leaves zero as the older history sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_restart_reg) |=> (left_prev2_reg == '0) && (right_prev2_reg == '0))
        else $error("restart did not clear the history");

    // An empty input register never blocks the slave channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while the input register is empty");
`endif

endmodule
